>>> rtl/bps_pkg.sv
// Beep pattern sequencer package: pattern table, widths and lookup functions.
// No dependencies; used by bps_item_if and by beep_pattern_sequencer.
`timescale 1ns / 1ps
`default_nettype none

package bps_pkg;

  // Longest pattern that the sequencer plays (steps beyond read as zero length)
  localparam int MAX_STEPS     = 8;
  localparam int PATTERN_COUNT = 9;
  localparam int TABLE_COLS    = 8;

  localparam int EFFECT_W = 4;
  localparam int TIME_W   = 32;
  localparam int STEP_W   = 3;
  localparam int DUR_W    = 10;
  localparam int LEN_W    = 5;

  // Item kinds
  localparam logic ACT_UPDATE = 1'b0;
  localparam logic ACT_START  = 1'b1;

  typedef logic [DUR_W-1:0] dur_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam dur_t DURATIONS [PATTERN_COUNT][TABLE_COLS] = '{
    '{10'd0,   10'd0,  10'd0,   10'd0,  10'd0,   10'd0, 10'd0, 10'd0},
    '{10'd25,  10'd0,  10'd0,   10'd0,  10'd0,   10'd0, 10'd0, 10'd0},
    '{10'd50,  10'd40, 10'd50,  10'd0,  10'd0,   10'd0, 10'd0, 10'd0},
    '{10'd45,  10'd0,  10'd0,   10'd0,  10'd0,   10'd0, 10'd0, 10'd0},
    '{10'd15,  10'd20, 10'd15,  10'd0,  10'd0,   10'd0, 10'd0, 10'd0},
    '{10'd120, 10'd0,  10'd0,   10'd0,  10'd0,   10'd0, 10'd0, 10'd0},
    '{10'd250, 10'd0,  10'd0,   10'd0,  10'd0,   10'd0, 10'd0, 10'd0},
    '{10'd100, 10'd50, 10'd100, 10'd50, 10'd300, 10'd0, 10'd0, 10'd0},
    '{10'd700, 10'd0,  10'd0,   10'd0,  10'd0,   10'd0, 10'd0, 10'd0}
  };

  localparam len_t STEP_COUNTS [PATTERN_COUNT] = '{
    5'd0, 5'd1, 5'd3, 5'd1, 5'd3, 5'd1, 5'd1, 5'd5, 5'd1
  };

  // Number of steps of a pattern, clipped to MAX_STEPS
  function automatic len_t pattern_length(input logic [EFFECT_W-1:0] p);
    len_t n;
    n = '0;
    if (int'(p) < PATTERN_COUNT) begin
      n = STEP_COUNTS[p];
      if (int'(n) > MAX_STEPS) begin
        n = LEN_W'(MAX_STEPS);
      end
    end
    return n;
  endfunction

  // Duration of one step; outside the table it is zero
  function automatic dur_t step_duration(input logic [EFFECT_W-1:0] p,
                                         input logic [STEP_W-1:0]   s);
    dur_t d;
    d = '0;
    if (int'(p) < PATTERN_COUNT && int'(s) < TABLE_COLS && int'(s) < MAX_STEPS) begin
      d = DURATIONS[p][s];
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bps_item_if.sv
// Input channel of the beep pattern sequencer: valid/ready with one item.
// Depends on bps_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bps_item_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [bps_pkg::EFFECT_W-1:0]  effect;
  logic [bps_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, output action, output effect, output now_ms,
                  input ready);
  modport sink   (input valid, input action, input effect, input now_ms,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/bps_result_if.sv
// Output channel of the beep pattern sequencer: valid/ready with one result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bps_result_if;
  logic valid;
  logic ready;
  logic buzzer_on;
  logic playing;

  modport source (output valid, output buzzer_on, output playing, input ready);
  modport sink   (input valid, input buzzer_on, input playing, output ready);
endinterface

`default_nettype wire

>>> rtl/beep_pattern_sequencer.sv
// Beep pattern sequencer top level: input register, state update, result register.
// Depends on bps_pkg, bps_item_if and bps_result_if.
//
//   channel  dir  payload                        transfer when
//   item     in   action, effect[3:0], now_ms    item.valid & item.ready
//   result   out  buzzer_on, playing             result.valid & result.ready
//
// One item per cycle sustained while result.ready holds; an item transfer loads
// the input register, and the result register loads from it when the result
// side can take it. The pattern state is updated in the same cycle that the
// result is loaded, so the rate-limiting loop is the step-timing subtract/compare.
// rst is synchronous; it clears state and both stage valids.
// A stalled result holds the input register; item.ready drops only when both
// stages are full.
`timescale 1ns / 1ps
`default_nettype none

module beep_pattern_sequencer (
  input  wire          clk,
  input  wire          rst,
  bps_item_if.sink     item,
  bps_result_if.source result
);

  // Input stage
  logic                         in_valid;
  logic                         in_action;
  logic [bps_pkg::EFFECT_W-1:0] in_effect;
  logic [bps_pkg::TIME_W-1:0]   in_now;

  // Pattern state
  logic [bps_pkg::EFFECT_W-1:0] active_pattern;
  logic [bps_pkg::STEP_W-1:0]   step_index;
  logic [bps_pkg::TIME_W-1:0]   step_start_ms;
  logic                         play_flag;
  logic                         sound_level;

  logic [bps_pkg::EFFECT_W-1:0] active_pattern_next;
  logic [bps_pkg::STEP_W-1:0]   step_index_next;
  logic [bps_pkg::TIME_W-1:0]   step_start_ms_next;
  logic                         play_flag_next;
  logic                         sound_level_next;

  // Result stage
  logic out_valid;
  logic out_buzzer;
  logic out_playing;

  logic advance;
  logic [bps_pkg::TIME_W-1:0] elapsed;
  logic [bps_pkg::STEP_W-1:0] step_inc;
  bps_pkg::dur_t              cur_dur;

  assign advance    = in_valid && (!out_valid || result.ready);
  assign item.ready = !in_valid || advance;

  assign result.valid     = out_valid;
  assign result.buzzer_on = out_buzzer;
  assign result.playing   = out_playing;

  assign elapsed  = in_now - step_start_ms;
  assign cur_dur  = bps_pkg::step_duration(active_pattern, step_index);
  assign step_inc = step_index + bps_pkg::STEP_W'(1);

  // Next pattern state for the item held in the input register
  always_comb begin
    active_pattern_next = active_pattern;
    step_index_next     = step_index;
    step_start_ms_next  = step_start_ms;
    play_flag_next      = play_flag;
    sound_level_next    = sound_level;
    if (in_action == bps_pkg::ACT_START) begin
      if (int'(in_effect) < bps_pkg::PATTERN_COUNT) begin
        active_pattern_next = in_effect;
        if (bps_pkg::pattern_length(in_effect) == '0) begin
          play_flag_next   = 1'b0;
          sound_level_next = 1'b0;
        end else begin
          step_index_next    = '0;
          step_start_ms_next = in_now;
          play_flag_next     = 1'b1;
          sound_level_next   = 1'b1;
        end
      end
    end else if (play_flag) begin
      if (elapsed >= {{(bps_pkg::TIME_W-bps_pkg::DUR_W){1'b0}}, cur_dur}) begin
        step_index_next    = step_inc;
        step_start_ms_next = in_now;
        if ({{(bps_pkg::LEN_W-bps_pkg::STEP_W){1'b0}}, step_inc}
            < bps_pkg::pattern_length(active_pattern)) begin
          sound_level_next = !step_inc[0];
        end else begin
          play_flag_next   = 1'b0;
          sound_level_next = 1'b0;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      in_action <= item.action;
      in_effect <= item.effect;
      in_now    <= item.now_ms;
    end
  end

  // State and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_pattern <= '0;
      step_index     <= '0;
      step_start_ms  <= '0;
      play_flag      <= 1'b0;
      sound_level    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        active_pattern <= active_pattern_next;
        step_index     <= step_index_next;
        step_start_ms  <= step_start_ms_next;
        play_flag      <= play_flag_next;
        sound_level    <= sound_level_next;
        out_valid      <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_buzzer  <= sound_level_next;
      out_playing <= play_flag_next;
    end
  end

  // Buzzer only sounds while a pattern plays
  a_sound_needs_play: assert property (@(posedge clk) disable iff (rst)
    sound_level |-> play_flag)
    else $error("buzzer on while not playing");

  // A playing pattern is a real one and its step is inside it
  a_play_in_range: assert property (@(posedge clk) disable iff (rst)
    play_flag |-> (active_pattern != '0) &&
                  ({{(bps_pkg::LEN_W-bps_pkg::STEP_W){1'b0}}, step_index}
                   < bps_pkg::pattern_length(active_pattern)))
    else $error("playing with bad pattern or step");

  // A held item is not overwritten while the result side stalls
  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_now) && $stable(in_effect))
    else $error("input register lost a stalled item");

  // State changes only when an item moves into the result register
  a_state_quiet: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(step_start_ms) && $stable(play_flag))
    else $error("state changed without an item");

endmodule

`default_nettype wire
